### sv/oltok_pkg.sv
package oltok_pkg;

   // Character codes the scanner reacts to.
   localparam logic [7:0] CH_EOS       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   // Field length counter width and response queue depth.
   localparam int LEN_W       = 8;
   localparam int RSPQ_DEPTH  = 4;
   localparam int RSPQ_PTR_W  = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_LVL_W  = $clog2(RSPQ_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_LINE_START = 3'd0,
      MODE_COMMENT    = 3'd1,
      MODE_FIELD      = 3'd2,
      MODE_BLANKS     = 3'd3,
      MODE_ENDED      = 3'd4
   } scan_mode_type;

   typedef enum logic [2:0] {
      KIND_CHAR      = 3'd0,
      KIND_FIELD_END = 3'd1,
      KIND_EOL       = 3'd2,
      KIND_EOF       = 3'd3,
      KIND_OVERFLOW  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_out;
      logic       last;
   } result_type;

   // Up to two results produced by one request, in order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_type;

endpackage

### sv/oltok_scan.sv
module oltok_scan #(
   parameter int FIELD_BUFFER_BYTES = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         char_in,
   output oltok_pkg::step_type step
);
   import oltok_pkg::*;

   localparam logic [LEN_W-1:0] LIMIT = LEN_W'(FIELD_BUFFER_BYTES);

   scan_mode_type    mode_ff, mode_in;
   logic             esc_ff, esc_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] len_inc;
   logic             blank;
   logic             take_char;

   // Scanner state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINE_START;
         esc_ff  <= 1'b0;
         len_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         len_ff  <= len_in;
      end
   end

   assign blank   = (char_in == CH_SPACE) || (char_in == CH_TAB);
   assign len_inc = len_ff + LEN_W'(1);

   // Next mode and the results of the current request.
   always_comb begin
      mode_in   = mode_ff;
      esc_in    = esc_ff;
      len_in    = len_ff;
      take_char = 1'b0;
      step      = '0;
      if (step_en) begin
         if ((mode_ff != MODE_LINE_START) && (mode_ff != MODE_COMMENT) &&
             (mode_ff != MODE_FIELD) && (mode_ff != MODE_BLANKS)) begin
            esc_in = 1'b0;
         end else if ((char_in == CH_BACKSLASH) && !esc_ff) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            unique case (mode_ff)
               MODE_LINE_START: begin
                  if (char_in == CH_EOS) begin
                     mode_in          = MODE_ENDED;
                     step.count       = 2'd1;
                     step.first.kind  = KIND_EOF;
                  end else if (blank || (char_in == CH_NEWLINE)) begin
                     mode_in = mode_ff;
                  end else if (char_in == CH_HASH) begin
                     mode_in = MODE_COMMENT;
                  end else begin
                     mode_in   = MODE_FIELD;
                     take_char = 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (char_in == CH_EOS) begin
                     mode_in          = MODE_ENDED;
                     step.count       = 2'd1;
                     step.first.kind  = KIND_EOF;
                  end else if ((char_in == CH_NEWLINE) && !esc_ff) begin
                     mode_in = MODE_LINE_START;
                  end
               end
               MODE_FIELD: begin
                  if (blank) begin
                     len_in          = '0;
                     mode_in         = MODE_BLANKS;
                     step.count      = 2'd1;
                     step.first.kind = KIND_FIELD_END;
                  end else if (char_in == CH_NEWLINE) begin
                     len_in          = '0;
                     step.first.kind = KIND_FIELD_END;
                     if (esc_ff) begin
                        mode_in    = MODE_BLANKS;
                        step.count = 2'd1;
                     end else begin
                        mode_in          = MODE_LINE_START;
                        step.count       = 2'd2;
                        step.second.kind = KIND_EOL;
                     end
                  end else if (char_in == CH_EOS) begin
                     len_in           = '0;
                     mode_in          = MODE_ENDED;
                     step.count       = 2'd2;
                     step.first.kind  = KIND_FIELD_END;
                     step.second.kind = KIND_EOF;
                  end else begin
                     take_char = 1'b1;
                  end
               end
               MODE_BLANKS: begin
                  if (char_in == CH_EOS) begin
                     mode_in         = MODE_ENDED;
                     step.count      = 2'd1;
                     step.first.kind = KIND_EOF;
                  end else if (blank) begin
                     mode_in = mode_ff;
                  end else if (char_in == CH_NEWLINE) begin
                     if (!esc_ff) begin
                        mode_in = MODE_LINE_START;
                     end
                  end else begin
                     mode_in   = MODE_FIELD;
                     take_char = 1'b1;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase

            // A field character either passes on or overflows the buffer.
            if (take_char) begin
               len_in     = len_inc;
               step.count = 2'd1;
               if (len_inc >= LIMIT) begin
                  mode_in         = MODE_ENDED;
                  step.first.kind = KIND_OVERFLOW;
               end else begin
                  step.first.kind     = KIND_CHAR;
                  step.first.char_out = char_in;
               end
            end
         end
      end
      // Mark the final result of this request.
      step.first.last  = (step.count == 2'd1);
      step.second.last = (step.count == 2'd2);
   end

endmodule

### sv/oltok_rspq.sv
module oltok_rspq (
   input  logic                  clock,
   input  logic                  reset,
   input  oltok_pkg::step_type   step,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output oltok_pkg::result_type head
);
   import oltok_pkg::*;

   result_type              mem [RSPQ_DEPTH];
   logic [RSPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_LVL_W-1:0]   level_ff, level_in;
   logic                    pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (level_ff != '0);
   assign room      = (level_ff <= RSPQ_LVL_W'(RSPQ_DEPTH - 2));
   assign head      = mem[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSPQ_PTR_W'(step.count);
      rd_ptr_in = rd_ptr_ff + RSPQ_PTR_W'(pop);
      level_in  = level_ff + RSPQ_LVL_W'(step.count) - RSPQ_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Result storage, written one or two entries at a time.
   always_ff @(posedge clock) begin
      if (step.count != 2'd0) begin
         mem[wr_ptr_ff] <= step.first;
      end
      if (step.count == 2'd2) begin
         mem[wr_ptr_ff + RSPQ_PTR_W'(1)] <= step.second;
      end
   end

endmodule

### sv/obj_line_tokenizer_unit.sv
// Results of a request are written into a registered result queue and offered on the
// rsp_ side from there.
// Throughput: one request per cycle while req_ready is high; a request with two results is
// buffered in a four-entry result queue that holds req_ready low when fewer than two
// entries are free.
// Reset: synchronous; the scanner returns to line start and the result queue empties.
module obj_line_tokenizer_unit #(
   parameter int FIELD_BUFFER_BYTES = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output oltok_pkg::kind_type rsp_kind,
   output logic [7:0]          rsp_char_out,
   output logic                rsp_last
);
   import oltok_pkg::*;

   step_type   step;
   result_type head;
   logic       room;
   logic       req_fire;

   assign req_ready = room;
   assign req_fire  = req_valid && req_ready;

   // Character scanner.
   oltok_scan #(
      .FIELD_BUFFER_BYTES(FIELD_BUFFER_BYTES)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_fire),
      .char_in (req_char_in),
      .step    (step)
   );

   // Result queue.
   oltok_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_kind     = head.kind;
   assign rsp_char_out = head.char_out;
   assign rsp_last     = head.last;

   // A stalled request side means results are waiting.
   a_stall_has_data: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with an empty result queue");

   // Only field characters carry a character.
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_CHAR) |-> (rsp_char_out == 8'h00))
      else $error("non-character result carries a character");

   // End of file and overflow always close out their request.
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_EOF) || (rsp_kind == KIND_OVERFLOW)) |-> rsp_last)
      else $error("end of file or overflow result not marked last");

   // End of line always follows a field end within the same request.
   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EOL) |-> rsp_last)
      else $error("end of line result not marked last");

endmodule
